// ===== src/crpe_pkg.sv =====
// crpe_pkg: shared types, widths and opcodes of the catmull-rom point evaluator
// used by every module under src; depends on nothing else
package crpe_pkg;

	localparam int COORD_W     = 16;
	localparam int POS_W       = 16;
	localparam int FRAC_BITS   = 12;
	localparam int NUM_POINTS  = 16;
	localparam int WINDOW      = 4;
	localparam int IDX_W       = $clog2(NUM_POINTS);
	localparam int SEG_W       = POS_W - FRAC_BITS;
	localparam int BANKS       = WINDOW;
	localparam int BANK_W      = $clog2(BANKS);
	localparam int BANK_ROWS   = NUM_POINTS / BANKS;
	localparam int ROW_W       = IDX_W - BANK_W;
	localparam int WORD_W      = 2 * COORD_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// datapath widths, each sized for the worst case of the stage feeding it
	localparam int A_W   = COORD_W + 4;
	localparam int C_W   = COORD_W + 1;
	localparam int M1_W  = A_W + FRAC_BITS + 2;
	localparam int ACC_W = M1_W + FRAC_BITS + 2;
	localparam int MID_W = ACC_W - FRAC_BITS;
	localparam int TOT_W = MID_W + FRAC_BITS + 2;
	localparam int R_W   = TOT_W - 2 * FRAC_BITS - 1;

	localparam logic signed [TOT_W-1:0] RND_HALF = TOT_W'(1) << (2 * FRAC_BITS);
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef struct packed {
		logic                      op;
		logic [IDX_W-1:0]          point_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [POS_W-1:0]          position;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] curve_x;
		logic signed [COORD_W-1:0] curve_y;
		logic                      range_error;
	} out_item_t;

	// decoded command held in the queue between front and back
	typedef struct packed {
		logic                         wr_en;
		logic                         rd_en;
		logic                         range_err;
		logic [BANK_W-1:0]            wr_bank;
		logic [ROW_W-1:0]             wr_row;
		logic [WORD_W-1:0]            wr_data;
		logic [BANKS-1:0][ROW_W-1:0]  rd_row;
		logic [BANK_W-1:0]            rot;
		logic [FRAC_BITS-1:0]         frac;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

endpackage

// ===== src/crpe_front.sv =====
// crpe_front: decodes an accepted item into a queue command
// bank and row addressing of the point window; uses crpe_pkg
module crpe_front (
	input  crpe_pkg::in_item_t item,
	output crpe_pkg::cmd_t     cmd
);
	import crpe_pkg::*;

	logic [SEG_W-1:0]  seg;
	logic [BANK_W-1:0] rot;
	logic [IDX_W-1:0]  pt [BANKS];

	assign seg = item.position[POS_W-1:FRAC_BITS];
	assign rot = BANK_W'(seg);

	always_comb begin
		// bank k holds every point whose index is k modulo the bank count
		for (int k = 0; k < BANKS; k++) begin
			pt[k] = IDX_W'(seg) + IDX_W'(BANK_W'(BANK_W'(k) - rot));
		end
	end

	always_comb begin
		cmd.wr_en     = (item.op == OP_LOAD) && (32'(item.point_index) < NUM_POINTS);
		cmd.rd_en     = (item.op == OP_EVAL);
		cmd.range_err = (32'(seg) + 32'(WINDOW - 1)) >= NUM_POINTS;
		cmd.wr_bank   = item.point_index[BANK_W-1:0];
		cmd.wr_row    = item.point_index[IDX_W-1:BANK_W];
		cmd.wr_data   = {item.point_y, item.point_x};
		for (int k = 0; k < BANKS; k++) begin
			cmd.rd_row[k] = pt[k][IDX_W-1:BANK_W];
		end
		cmd.rot  = rot;
		cmd.frac = item.position[FRAC_BITS-1:0];
	end

endmodule

// ===== src/crpe_queue.sv =====
// crpe_queue: short command queue between front and back
// holds crpe_pkg::cmd_t entries; uses crpe_pkg
module crpe_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  crpe_pkg::cmd_t       push_cmd,
	input  logic                 pop,
	output crpe_pkg::cmd_t       head,
	output crpe_pkg::q_status_t  status
);
	import crpe_pkg::*;

	cmd_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QPTR_W:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= push_cmd;
	end

	assign head            = slot_q[rptr_q];
	assign status.full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign status.nonempty = (count_q != '0);

endmodule

// ===== src/crpe_back.sv =====
// crpe_back: banked point store and the weighted-sum pipeline
// takes commands from crpe_queue, drives the result register; uses crpe_pkg
module crpe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crpe_pkg::cmd_t       head,
	input  crpe_pkg::q_status_t  qstat,
	output logic                 pop,
	output crpe_pkg::out_item_t  result,
	output logic                 result_valid,
	input  logic                 result_stall
);
	import crpe_pkg::*;

	logic [WORD_W-1:0] mem [BANKS][BANK_ROWS];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, out_vld_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	logic rd_fire;

	logic [BANKS-1:0][WORD_W-1:0] rd_s1;
	logic [BANK_W-1:0]            rot_s1;
	logic [FRAC_BITS-1:0]         frac_s1, frac_s2, frac_s3, frac_s4;
	logic                         err_s1, err_s2, err_s3, err_s4, err_s5;
	out_item_t                    out_q;

	logic [2*BANKS*WORD_W-1:0] dbl_word;
	logic [BANKS*WORD_W-1:0]   rot_word;
	logic signed [COORD_W-1:0] lane_res [2];

	// each stage moves when its successor is free or moving
	assign rdy6 = !out_vld_q || !result_stall;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	// loads retire at the store and never wait on the pipeline
	assign pop     = qstat.nonempty && (!head.rd_en || rdy1);
	assign rd_fire = pop && head.rd_en;

	always_ff @(posedge clk) begin
		for (int k = 0; k < BANKS; k++) begin
			if (pop && head.wr_en && (head.wr_bank == BANK_W'(k))) begin
				mem[k][head.wr_row] <= head.wr_data;
			end
			if (rd_fire) begin
				rd_s1[k] <= mem[k][head.rd_row[k]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= rd_fire;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) out_vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_fire) begin
			rot_s1  <= head.rot;
			frac_s1 <= head.frac;
			err_s1  <= head.range_err;
		end
		if (rdy2) begin
			frac_s2 <= frac_s1;
			err_s2  <= err_s1;
		end
		if (rdy3) begin
			frac_s3 <= frac_s2;
			err_s3  <= err_s2;
		end
		if (rdy4) begin
			frac_s4 <= frac_s3;
			err_s4  <= err_s3;
		end
		if (rdy5) begin
			err_s5 <= err_s4;
		end
		if (rdy6) begin
			out_q.range_error <= err_s5;
			out_q.curve_x     <= err_s5 ? '0 : lane_res[0];
			out_q.curve_y     <= err_s5 ? '0 : lane_res[1];
		end
	end

	// bring the window into point order: rotate banks by the segment's low bits
	assign dbl_word = {rd_s1, rd_s1};
	assign rot_word = (BANKS*WORD_W)'(dbl_word >> (32'(rot_s1) * WORD_W));

	for (genvar ax = 0; ax < 2; ax++) begin : g_lane
		logic signed [A_W-1:0]                e [WINDOW];
		logic signed [A_W-1:0]                a_s2, b_s2;
		logic signed [C_W-1:0]                c_s2, d_s2, c_s3, d_s3, d_s4;
		logic signed [FRAC_BITS:0]            fs2, fs3, fs4;
		logic signed [A_W+FRAC_BITS:0]        prod1;
		logic signed [A_W+FRAC_BITS-1:0]      b_sh;
		logic signed [M1_W-1:0]               m1, m1_s3;
		logic signed [M1_W+FRAC_BITS:0]       prod2;
		logic signed [C_W+2*FRAC_BITS-1:0]    c_sh, d_sh;
		logic signed [ACC_W-1:0]              acc, acc_s4;
		logic signed [MID_W-1:0]              mid;
		logic signed [MID_W+FRAC_BITS:0]      prod3;
		logic signed [TOT_W-1:0]              tot, tot_s5, rnd;
		logic signed [R_W-1:0]                rq;
		logic [R_W-COORD_W:0]                 upper;

		always_comb begin
			for (int i = 0; i < WINDOW; i++) begin
				e[i] = A_W'(signed'(rot_word[i*WORD_W + ax*COORD_W +: COORD_W]));
			end
		end

		assign fs2 = signed'({1'b0, frac_s2});
		assign fs3 = signed'({1'b0, frac_s3});
		assign fs4 = signed'({1'b0, frac_s4});

		// stage 2: a*f + b*S
		assign prod1 = a_s2 * fs2;
		assign b_sh  = signed'({b_s2, {FRAC_BITS{1'b0}}});
		assign m1    = prod1 + b_sh;

		// stage 3: (a*f + b*S)*f + c*S*S
		assign prod2 = m1_s3 * fs3;
		assign c_sh  = signed'({c_s3, {(2*FRAC_BITS){1'b0}}});
		assign acc   = prod2 + c_sh;

		// stage 4: floor(acc/S)*f + d*S*S
		assign mid   = signed'(acc_s4[ACC_W-1:FRAC_BITS]);
		assign prod3 = mid * fs4;
		assign d_sh  = signed'({d_s4, {(2*FRAC_BITS){1'b0}}});
		assign tot   = prod3 + d_sh;

		// stage 5: divide by 2*S*S with round half up, then saturate
		assign rnd   = tot_s5 + RND_HALF;
		assign rq    = signed'(rnd[TOT_W-1:2*FRAC_BITS+1]);
		assign upper = rq[R_W-1:COORD_W-1];

		always_comb begin
			if ((&upper) || !(|upper)) begin
				lane_res[ax] = signed'(rq[COORD_W-1:0]);
			end else if (rq[R_W-1]) begin
				lane_res[ax] = COORD_MIN;
			end else begin
				lane_res[ax] = COORD_MAX;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy2) begin
				a_s2 <= A_W'(e[3] - e[0] + 3 * (e[1] - e[2]));
				b_s2 <= A_W'(2 * e[0] - 5 * e[1] + 4 * e[2] - e[3]);
				c_s2 <= C_W'(e[2] - e[0]);
				d_s2 <= C_W'(2 * e[1]);
			end
			if (rdy3) begin
				m1_s3 <= m1;
				c_s3  <= c_s2;
				d_s3  <= d_s2;
			end
			if (rdy4) begin
				acc_s4 <= acc;
				d_s4   <= d_s3;
			end
			if (rdy5) begin
				tot_s5 <= tot;
			end
		end
	end

	assign result       = out_q;
	assign result_valid = out_vld_q;

endmodule

// ===== src/catmull_rom_point_eval.sv =====
// catmull_rom_point_eval: top level of the catmull-rom point evaluator
// instantiates crpe_front, crpe_queue and crpe_back; uses crpe_pkg
//
// usage:
// item/item_valid/item_stall is the input channel, result/result_valid/
// result_stall the output channel; a transaction completes on a rising edge
// with valid high and stall low.
// a load item writes one control point into the banked point store and
// gives no result. an evaluate item gives exactly one result; the four
// window points are read in the same cycle because the store is split
// into four banks by index. throughput is one item per cycle while
// result_stall stays low, set by the fully pipelined multiply chain
// (three multipliers per axis, one in each of stages 2 to 4).
// a four-entry command queue parts the front from the back: items keep
// being taken while results wait, and item_stall rises only once the queue
// is full behind a stalled result_stall.
// reset clears the queue and all pipeline valids; the point store is not
// cleared, so points must be loaded before any evaluate uses them.
// a segment whose window runs off the table returns range_error with zeros.
module catmull_rom_point_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crpe_pkg::in_item_t   item,
	input  logic                 item_valid,
	output logic                 item_stall,
	output crpe_pkg::out_item_t  result,
	output logic                 result_valid,
	input  logic                 result_stall
);
	import crpe_pkg::*;

	cmd_t      front_cmd;
	cmd_t      q_head;
	q_status_t qstat;
	logic      q_push;
	logic      q_pop;

	assign item_stall = qstat.full;
	assign q_push     = item_valid && !item_stall;

	crpe_front u_front (
		.item (item),
		.cmd  (front_cmd)
	);

	crpe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.status   (qstat)
	);

	crpe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.qstat        (qstat),
		.pop          (q_pop),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	// out-of-range segments must come back with zero coordinates
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.range_error |-> result.curve_x == '0 && result.curve_y == '0)
		else $error("range error result carries non-zero coordinates");

	// the back never takes a command from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> qstat.nonempty)
		else $error("queue popped while empty");

	// nothing leaves the block in the first cycle after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !result_valid)
		else $error("result valid straight after reset");

endmodule

// ===== test/tb_catmull_rom_point_eval.sv =====
`timescale 1ns / 100ps
// tb_catmull_rom_point_eval: self-checking testbench for the catmull-rom point evaluator
// drives loads and evaluations with random idling on both channels; uses crpe_pkg
module tb_catmull_rom_point_eval;
	import crpe_pkg::*;

	localparam int RAND_ITEMS = 1130;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n = 1'b0;
	in_item_t  item = '0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	out_item_t result;
	logic      result_valid;
	logic      result_stall = 1'b0;

	// predictor copy of the point store
	logic signed [COORD_W-1:0] x_pts [NUM_POINTS];
	logic signed [COORD_W-1:0] y_pts [NUM_POINTS];
	logic [NUM_POINTS-1:0]     loaded_mask = '0;

	out_item_t pending_points [$];
	int        errors = 0;
	int        n_loads = 0;
	int        n_evals = 0;
	int        n_off_table = 0;
	int        n_clipped = 0;
	int        cycle_cnt = 0;
	int        no_gap_run = 0;
	int        stall_left = 0;

	catmull_rom_point_eval u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, pending_points.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// one axis of the spline point, exact integer form with a final half-up round
	function automatic logic signed [COORD_W-1:0] catmull_axis(
		input logic signed [COORD_W-1:0] p0, p1, p2, p3,
		input logic [FRAC_BITS-1:0] frac
	);
		longint s, f, a, b, c, d, acc, mid, tot, r;
		s = longint'(1) << FRAC_BITS;
		f = longint'(frac);
		a = -longint'(p0) + 3 * longint'(p1) - 3 * longint'(p2) + longint'(p3);
		b = 2 * longint'(p0) - 5 * longint'(p1) + 4 * longint'(p2) - longint'(p3);
		c = longint'(p2) - longint'(p0);
		d = 2 * longint'(p1);
		acc = (a * f + b * s) * f + c * s * s;
		mid = acc >>> FRAC_BITS;
		tot = mid * f + d * s * s;
		r = (tot + s * s) >>> (2 * FRAC_BITS + 1);
		if (r > 32767) begin
			r = 32767;
			n_clipped++;
		end else if (r < -32768) begin
			r = -32768;
			n_clipped++;
		end
		return COORD_W'(r);
	endfunction

	// update the point store or queue the expected curve point
	task automatic predict_item(input in_item_t it, input bit typed, input out_item_t want);
		out_item_t exp_pt;
		int        seg;
		seg = int'(it.position >> FRAC_BITS);
		if (it.op == OP_LOAD) begin
			n_loads++;
			x_pts[it.point_index] = it.point_x;
			y_pts[it.point_index] = it.point_y;
			loaded_mask[it.point_index] = 1'b1;
		end else begin
			n_evals++;
			exp_pt = '0;
			if (seg + 3 >= NUM_POINTS) begin
				exp_pt.range_error = 1'b1;
				n_off_table++;
			end else begin
				exp_pt.curve_x = catmull_axis(x_pts[seg], x_pts[seg+1], x_pts[seg+2],
					x_pts[seg+3], it.position[FRAC_BITS-1:0]);
				exp_pt.curve_y = catmull_axis(y_pts[seg], y_pts[seg+1], y_pts[seg+2],
					y_pts[seg+3], it.position[FRAC_BITS-1:0]);
			end
			pending_points.push_back(typed ? want : exp_pt);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
		int gap;
		if (no_gap_run > 0) begin
			no_gap_run--;
			gap = 0;
		end else begin
			gap = pick_gap();
			if ($urandom_range(99) < 3)
				no_gap_run = $urandom_range(40, 100);
		end
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		predict_item(it, typed, want);
	endtask

	// receiver back-pressure: alternating free and stalled stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!result_stall) begin
			result_stall <= 1'b1;
			stall_left <= ($urandom_range(99) < 80) ? $urandom_range(0, 2) : $urandom_range(8, 40);
		end else begin
			result_stall <= 1'b0;
			stall_left <= ($urandom_range(99) < 70) ? $urandom_range(0, 5) : $urandom_range(20, 100);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_points.size() == 0) begin
				errors++;
				$display("%0t: unexpected result x %0d y %0d range_error %0b", $time,
					result.curve_x, result.curve_y, result.range_error);
			end else begin
				want = pending_points.pop_front();
				if (result.curve_x !== want.curve_x) begin
					errors++;
					$display("%0t: curve_x expected %0d got %0d", $time, want.curve_x,
						result.curve_x);
				end
				if (result.curve_y !== want.curve_y) begin
					errors++;
					$display("%0t: curve_y expected %0d got %0d", $time, want.curve_y,
						result.curve_y);
				end
				if (result.range_error !== want.range_error) begin
					errors++;
					$display("%0t: range_error expected %0b got %0b", $time,
						want.range_error, result.range_error);
				end
			end
		end
	end

	function automatic dir_row_t load_row(input int idx, input logic signed [COORD_W-1:0] x, y);
		dir_row_t row;
		row.stim = '0;
		row.stim.op = OP_LOAD;
		row.stim.point_index = IDX_W'(idx);
		row.stim.point_x = x;
		row.stim.point_y = y;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic dir_row_t eval_known(input logic [POS_W-1:0] pos,
		input logic signed [COORD_W-1:0] x, y, input logic err);
		dir_row_t row;
		row.stim = '0;
		row.stim.op = OP_EVAL;
		row.stim.position = pos;
		row.typed = 1'b1;
		row.want.curve_x = x;
		row.want.curve_y = y;
		row.want.range_error = err;
		return row;
	endfunction

	function automatic dir_row_t eval_row(input logic [POS_W-1:0] pos);
		dir_row_t row;
		row = eval_known(pos, '0, '0, 1'b0);
		row.typed = 1'b0;
		return row;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(15))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3: return '1;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	initial begin
		dir_row_t  dir_rows [20];
		in_item_t  it;
		int        windows [$];
		int        roll;
		int        seg;
		logic [FRAC_BITS-1:0] frac;

		dir_rows = '{
			// segments off the end of the table, nothing loaded yet
			eval_known(16'hD000, '0, '0, 1'b1),
			eval_known(16'hFFFF, '0, '0, 1'b1),
			load_row(0, COORD_MAX, COORD_MIN),
			load_row(1, COORD_MAX, COORD_MIN),
			load_row(2, COORD_MAX, COORD_MIN),
			load_row(3, COORD_MAX, COORD_MIN),
			// four equal points give a flat segment
			eval_known(16'h0000, COORD_MAX, COORD_MIN, 1'b0),
			eval_known(16'h0FFF, COORD_MAX, COORD_MIN, 1'b0),
			// alternating extremes give a segment that swings across the full range
			load_row(1, COORD_MIN, COORD_MAX),
			load_row(3, COORD_MIN, COORD_MAX),
			eval_row(16'h0800),
			eval_row(16'h0001),
			load_row(4, 16'sh0001, -16'sh0001),
			load_row(5, 16'sh1234, -16'sh1234),
			load_row(6, -16'sh0001, 16'sh0001),
			load_row(7, COORD_MAX, COORD_MIN),
			eval_known(16'h4000, 16'sh1234, -16'sh1234, 1'b0),
			eval_row(16'h4ABC),
			eval_row(16'h1000),
			eval_row(16'h3FFF)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

		for (int k = 0; k < RAND_ITEMS; k++) begin
			it.point_index = IDX_W'($urandom);
			it.point_x = rand_coord();
			it.point_y = rand_coord();
			it.position = POS_W'($urandom);
			windows.delete();
			for (int s = 0; s + 3 < NUM_POINTS; s++)
				if (&loaded_mask[s +: 4])
					windows.push_back(s);
			roll = $urandom_range(99);
			if (roll < 5) begin
				it.op = OP_EVAL;
				it.position = POS_W'($urandom_range(16'hD000, 16'hFFFF));
			end else if (roll < 40 || windows.size() == 0) begin
				it.op = OP_LOAD;
			end else begin
				it.op = OP_EVAL;
				seg = windows[$urandom_range(windows.size() - 1)];
				case ($urandom_range(9))
					0: frac = '0;
					1: frac = '1;
					default: frac = FRAC_BITS'($urandom);
				endcase
				it.position = {SEG_W'(seg), frac};
			end
			send_item(it, 1'b0, '0);
		end
		item_valid <= 1'b0;

		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d point loads and %0d evaluations", n_loads, n_evals);
		$display("%0d evaluations ran off the table, %0d axis values clipped",
			n_off_table, n_clipped);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
